// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character decode function for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

  // Status reported on the final item of a string
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Map one ASCII code to {invalid, sextet}; invalid characters give sextet 0
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] diff;
    logic [6:0] res;
    begin
      diff = 8'h00;
      res  = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
        diff = c - 8'h41;
        res  = {1'b0, diff[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        diff = c - 8'h61 + 8'd26;
        res  = {1'b0, diff[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        diff = c - 8'h30 + 8'd52;
        res  = {1'b0, diff[5:0]};
      end else if (c == 8'h2B) begin
        res = 7'd62;
      end else if (c == 8'h2F) begin
        res = 7'd63;
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_if.sv =====
// Channel interfaces of the base64 stream decoder: characters in, results out, configuration.
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       last_char;

  modport source (output valid, output in_char, output last_char, input ready);
  modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 is_status;
  b64d_pkg::status_t    status_code;
  logic                 last_item;

  modport source (output valid, output out_byte, output is_status, output status_code,
                  output last_item, input ready);
  modport sink   (input valid, input out_byte, input is_status, input status_code,
                  input last_item, output ready);
endinterface

interface b64d_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_output_bytes;

  modport source (output valid, output max_output_bytes, input ready);
  modport sink   (input valid, input max_output_bytes, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder.sv =====
// Path: an accepted character waits in the input register; its results are then loaded into the
// result register once that register is free.
// Throughput: one character per cycle while the result register is free; a character that yields
// results (up to 3 bytes plus the status item) holds the input until the single result register
// has drained them, one item per cycle while the output is ready.
// Reset: rst_n synchronous, active low; clears stream state, empties both registers and
// sets max_output_bytes to 255.
`default_nettype none

module base64_stream_decoder (
  input  wire          clk,
  input  wire          rst_n,
  b64d_in_if.sink      in_ch,
  b64d_out_if.source   out_ch,
  b64d_cfg_if.sink     cfg_ch
);

  // Configuration register
  logic [7:0] max_bytes_r;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // Stream state
  logic [17:0] sext_buf_r, sext_buf_nxt;
  logic [1:0]  grp_pos_r, grp_pos_nxt;
  logic [3:0]  pad_mask_r, pad_mask_nxt;
  logic [1:0]  len_mod4_r, len_mod4_nxt;
  logic        err_seen_r, err_seen_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  emitted_r, emitted_nxt;

  // Result register: remaining bytes (top first) and a pending status
  logic [23:0]         bnd_word_r, bnd_word_nxt;
  logic [1:0]          bnd_bytes_r, bnd_bytes_nxt;
  logic                bnd_stat_r, bnd_stat_nxt;
  b64d_pkg::status_t   bnd_code_r, bnd_code_nxt;

  logic out_pop;
  logic last_pop;
  logic bnd_free;
  logic advance;

  // Decode temporaries
  logic        is_pad;
  logic [6:0]  sx;
  logic        err_n;
  logic [5:0]  v0;
  logic [3:0]  pm;
  logic [23:0] word;
  logic [1:0]  keep;
  logic [7:0]  room;
  logic [1:0]  nb;
  logic [1:0]  len_inc;

  // Configuration write
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 8'd255;
    end else if (cfg_ch.valid) begin
      max_bytes_r <= cfg_ch.max_output_bytes;
    end
  end

  // Output side: drain the result register one item per request
  assign out_ch.valid       = (bnd_bytes_r != 2'd0) || bnd_stat_r;
  assign out_ch.is_status   = (bnd_bytes_r == 2'd0);
  assign out_ch.last_item   = (bnd_bytes_r == 2'd0);
  assign out_ch.out_byte    = (bnd_bytes_r != 2'd0) ? bnd_word_r[23:16] : 8'h00;
  assign out_ch.status_code = (bnd_bytes_r == 2'd0) ? bnd_code_r : b64d_pkg::ST_OK;

  assign out_pop  = out_ch.valid && out_ch.ready;
  assign last_pop = ((bnd_bytes_r == 2'd1) && !bnd_stat_r) ||
                    ((bnd_bytes_r == 2'd0) && bnd_stat_r);
  assign bnd_free = !out_ch.valid || (out_ch.ready && last_pop);
  assign advance  = in_vld_r && bnd_free;

  assign in_ch.ready = !in_vld_r || advance;

  // Input register: load on request, drop once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.in_char;
      in_last_r <= in_ch.last_char;
    end
  end

  // Decode one character against the open group
  always_comb begin
    is_pad  = (in_char_r == b64d_pkg::PAD_CHAR);
    sx      = b64d_pkg::sextet_of(in_char_r);
    err_n   = err_seen_r | (!is_pad & sx[6]);
    v0      = (is_pad | sx[6]) ? 6'd0 : sx[5:0];
    pm      = pad_mask_r | ({3'b000, is_pad} << grp_pos_r);
    word    = {sext_buf_r, v0};
    len_inc = len_mod4_r + 2'd1;

    if (pm[1]) begin
      keep = 2'd0;
    end else if (pm[2]) begin
      keep = 2'd1;
    end else if (pm[3]) begin
      keep = 2'd2;
    end else begin
      keep = 2'd3;
    end

    room = (max_bytes_r > emitted_r) ? (max_bytes_r - emitted_r) : 8'd0;
    nb   = (room < {6'd0, keep}) ? room[1:0] : keep;

    sext_buf_nxt = sext_buf_r;
    grp_pos_nxt  = grp_pos_r;
    pad_mask_nxt = pad_mask_r;
    err_seen_nxt = err_seen_r;
    stopped_nxt  = stopped_r;
    emitted_nxt  = emitted_r;
    len_mod4_nxt = len_mod4_r;

    bnd_word_nxt  = word;
    bnd_bytes_nxt = 2'd0;
    bnd_stat_nxt  = 1'b0;
    bnd_code_nxt  = b64d_pkg::ST_OK;

    if (!stopped_r) begin
      err_seen_nxt = err_n;
      if (grp_pos_r != 2'd3) begin
        sext_buf_nxt = word[17:0];
        grp_pos_nxt  = grp_pos_r + 2'd1;
        pad_mask_nxt = pm;
      end else begin
        if (!err_n) begin
          bnd_bytes_nxt = nb;
          emitted_nxt   = emitted_r + {6'd0, nb};
        end
        stopped_nxt  = (pm != 4'd0);
        sext_buf_nxt = 18'd0;
        grp_pos_nxt  = 2'd0;
        pad_mask_nxt = 4'd0;
      end
    end

    len_mod4_nxt = len_inc;

    // Close the string with a status item and clear the stream
    if (in_last_r) begin
      bnd_stat_nxt = 1'b1;
      if (len_inc != 2'd0) begin
        bnd_code_nxt = b64d_pkg::ST_BAD_LENGTH;
      end else if (err_seen_nxt) begin
        bnd_code_nxt = b64d_pkg::ST_INVALID;
      end else begin
        bnd_code_nxt = b64d_pkg::ST_OK;
      end
      sext_buf_nxt = 18'd0;
      grp_pos_nxt  = 2'd0;
      pad_mask_nxt = 4'd0;
      len_mod4_nxt = 2'd0;
      err_seen_nxt = 1'b0;
      stopped_nxt  = 1'b0;
      emitted_nxt  = 8'd0;
    end
  end

  // Advance stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sext_buf_r <= 18'd0;
      grp_pos_r  <= 2'd0;
      pad_mask_r <= 4'd0;
      len_mod4_r <= 2'd0;
      err_seen_r <= 1'b0;
      stopped_r  <= 1'b0;
      emitted_r  <= 8'd0;
    end else if (advance) begin
      sext_buf_r <= sext_buf_nxt;
      grp_pos_r  <= grp_pos_nxt;
      pad_mask_r <= pad_mask_nxt;
      len_mod4_r <= len_mod4_nxt;
      err_seen_r <= err_seen_nxt;
      stopped_r  <= stopped_nxt;
      emitted_r  <= emitted_nxt;
    end
  end

  // Result register: load a new set of results or step to the next item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_bytes_r <= 2'd0;
      bnd_stat_r  <= 1'b0;
    end else if (advance) begin
      bnd_bytes_r <= bnd_bytes_nxt;
      bnd_stat_r  <= bnd_stat_nxt;
    end else if (out_pop) begin
      if (bnd_bytes_r != 2'd0) begin
        bnd_bytes_r <= bnd_bytes_r - 2'd1;
      end else begin
        bnd_stat_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bnd_word_r <= bnd_word_nxt;
      bnd_code_r <= bnd_code_nxt;
    end else if (out_pop) begin
      bnd_word_r <= {bnd_word_r[15:0], 8'h00};
    end
  end

  // A shown status item means the stream state was already cleared
  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_status) |->
      (grp_pos_r == 2'd0 && len_mod4_r == 2'd0 && emitted_r == 8'd0 && !stopped_r))
    else $error("stream state not cleared under a status item");

  // A padded group leaves no open sextets behind
  a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (grp_pos_r == 2'd0 && sext_buf_r == 18'd0 && pad_mask_r == 4'd0))
    else $error("open group after decoding stopped");

  // A held character stays in the input register until processed
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_char_r) && $stable(in_last_r)))
    else $error("input register lost a pending character");

endmodule

`default_nettype wire
